[rtl/ttt_pkg.sv]
// Shared types and constants for the trapezoid travel time unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

    localparam int D_W     = 24;  // distance / velocity field width
    localparam int VI_W    = 25;  // start velocity after capping (signed)
    localparam int SQ_IN_W = 52;  // square root operand width
    localparam int SQ_W    = 26;  // square root result width
    localparam int NUM_W   = 51;  // dividend width
    localparam int DEN_W   = 49;  // divisor width
    localparam int T_W     = 32;  // time result width
    localparam int PROF_W  = 2;

    typedef enum logic [0:0] {
        CFG_SPEED_LIMIT = 1'b0,
        CFG_ACCEL_LIMIT = 1'b1
    } ttt_cfg_t;

    typedef enum logic [PROF_W-1:0] {
        PROF_REACH  = 2'd0,
        PROF_TRI    = 2'd1,
        PROF_CRUISE = 2'd2
    } ttt_prof_t;

    // which formula an item follows through the pipeline
    typedef enum logic [1:0] {
        CASE_ACCEL,
        CASE_DECEL,
        CASE_TRI,
        CASE_CRUISE
    } ttt_case_t;

    // carried alongside the square root
    typedef struct packed {
        ttt_case_t              sel;
        logic signed [VI_W-1:0] vi;
        logic [D_W-1:0]         vf;
        logic [NUM_W-1:0]       num;
        logic [DEN_W-1:0]       den;
    } ttt_side_t;

    // one divider stage: partial remainder, dividend bits shifting out at the
    // top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [T_W-1:0]   bits;
        logic [DEN_W-1:0] den;
        logic             sat;
        ttt_prof_t        prof;
    } ttt_div_t;

endpackage

`default_nettype wire

[rtl/ttt_isqrt_pipe.sv]
// Pipelined floored integer square root, one result bit per stage.
// Depends on ttt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttt_isqrt_pipe
    import ttt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic [SQ_IN_W-1:0] in_op,
    input  wire ttt_side_t          in_side,
    output logic                    out_valid,
    output logic [SQ_W-1:0]         out_root,
    output ttt_side_t               out_side
);

    logic [SQ_W-1:0]    val_reg;
    logic [SQ_W-1:0]    val_next;
    logic [SQ_IN_W-1:0] x_reg    [SQ_W];
    logic [SQ_IN_W-1:0] x_next   [SQ_W];
    logic [SQ_IN_W-1:0] res_reg  [SQ_W];
    logic [SQ_IN_W-1:0] res_next [SQ_W];
    ttt_side_t          side_reg [SQ_W];
    ttt_side_t          side_next[SQ_W];

    always_comb begin
        logic [SQ_IN_W-1:0] xp;
        logic [SQ_IN_W-1:0] rp;
        logic [SQ_IN_W-1:0] bitv;
        logic [SQ_IN_W-1:0] trial;
        for (int k = 0; k < SQ_W; k++) begin
            if (k == 0) begin
                xp           = in_op;
                rp           = '0;
                val_next[k]  = in_valid;
                side_next[k] = in_side;
            end else begin
                xp           = x_reg[k-1];
                rp           = res_reg[k-1];
                val_next[k]  = val_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            bitv  = SQ_IN_W'(1) << (2 * (SQ_W - 1 - k));
            trial = rp + bitv;
            if (xp >= trial) begin
                x_next[k]   = xp - trial;
                res_next[k] = (rp >> 1) + bitv;
            end else begin
                x_next[k]   = xp;
                res_next[k] = rp >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (adv) begin
            val_reg <= val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            res_reg  <= res_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = val_reg[SQ_W-1];
    assign out_root  = res_reg[SQ_W-1][SQ_W-1:0];
    assign out_side  = side_reg[SQ_W-1];

endmodule

`default_nettype wire

[rtl/ttt_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, T_W stages.
// Depends on ttt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttt_div_pipe
    import ttt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     adv,
    input  wire logic     in_valid,
    input  wire ttt_div_t in_div,
    output logic          out_valid,
    output ttt_div_t      out_div
);

    logic [T_W-1:0] val_reg;
    logic [T_W-1:0] val_next;
    ttt_div_t       st_reg [T_W];
    ttt_div_t       st_next[T_W];

    always_comb begin
        ttt_div_t     p;
        logic [DEN_W:0] sh;
        for (int k = 0; k < T_W; k++) begin
            if (k == 0) begin
                p           = in_div;
                val_next[k] = in_valid;
            end else begin
                p           = st_reg[k-1];
                val_next[k] = val_reg[k-1];
            end
            sh         = {p.rem, p.bits[T_W-1]};
            st_next[k] = p;
            if (sh >= {1'b0, p.den}) begin
                st_next[k].rem  = DEN_W'(sh - {1'b0, p.den});
                st_next[k].bits = {p.bits[T_W-2:0], 1'b1};
            end else begin
                st_next[k].rem  = sh[DEN_W-1:0];
                st_next[k].bits = {p.bits[T_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (adv) begin
            val_reg <= val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = val_reg[T_W-1];
    assign out_div   = st_reg[T_W-1];

endmodule

`default_nettype wire

[rtl/trapezoid_travel_time_unit.sv]
// Minimum travel time over a 1-D distance under speed and acceleration limits.
// Depends on ttt_pkg, ttt_isqrt_pipe and ttt_div_pipe.
//
// Takes one item per clock unless the result side stalls; returns one result
// per item, in order. There are 4 front stages (clamp, products, sums, case
// select), 26 square root stages (one root bit each), 1 stage that forms the
// dividend, 32 divider stages (one quotient bit each) and the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on the result side holds every stage in place.
// Configuration may only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_travel_time_unit
    import ttt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [0:0]            cfg_addr,
    input  wire logic [D_W-1:0]        cfg_wdata,
    // input items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [D_W-1:0] s_travel_distance,
    input  wire logic signed [D_W-1:0] s_start_velocity,
    input  wire logic signed [D_W-1:0] s_end_velocity,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [T_W-1:0]             m_travel_time,
    output logic [PROF_W-1:0]          m_profile,
    output logic                       m_saturated
);

    localparam int NSH_W = NUM_W + FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [D_W-1:0] speed_limit_reg;
    logic [D_W-1:0] accel_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg <= D_W'(196608);
            accel_limit_reg <= D_W'(196608);
        end else if (cfg_wr_en) begin
            case (ttt_cfg_t'(cfg_addr))
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_wdata;
                CFG_ACCEL_LIMIT: accel_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [D_W-1:0] vm;
    logic [D_W-1:0] acc;
    assign vm  = speed_limit_reg;
    assign acc = (accel_limit_reg == '0) ? D_W'(1) : accel_limit_reg;

    // global advance: everything moves unless a result sits unclaimed
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: bound the inputs ----------------
    logic                   v1_reg;
    logic [D_W-1:0]         d1_reg;
    logic signed [VI_W-1:0] vi1_reg;
    logic [D_W-1:0]         vf1_reg;
    logic [D_W-1:0]         d1_next;
    logic signed [VI_W-1:0] vi1_next;
    logic [D_W-1:0]         vf1_next;

    always_comb begin
        logic signed [VI_W-1:0] vi_ext;
        logic signed [VI_W-1:0] vm_ext;
        logic [D_W-1:0]         vf_pos;
        vi_ext   = {s_start_velocity[D_W-1], s_start_velocity};
        vm_ext   = $signed({1'b0, vm});
        vi1_next = (vi_ext > vm_ext) ? vm_ext : vi_ext;
        d1_next  = s_travel_distance[D_W-1] ? '0 : $unsigned(s_travel_distance);
        vf_pos   = s_end_velocity[D_W-1] ? '0 : $unsigned(s_end_velocity);
        vf1_next = (vf_pos > vm) ? vm : vf_pos;
    end

    // ---------------- stage 2: products ----------------
    logic                   v2_reg;
    logic [47:0]            vi2_reg;
    logic [47:0]            vf2_reg;
    logic [47:0]            ad2_reg;
    logic [49:0]            da2_reg;
    logic [47:0]            dd2_reg;
    logic [47:0]            vm2_reg;
    logic [47:0]            avm2_reg;
    logic signed [VI_W-1:0] vi2s_reg;
    logic [D_W-1:0]         vf2s_reg;
    logic [D_W-1:0]         a2_reg;
    logic [47:0]            vi2_next;
    logic [49:0]            da2_next;

    always_comb begin
        logic signed [49:0] vi_sq;
        logic signed [25:0] da_s;
        logic [24:0]        da_u;
        vi_sq    = 50'(vi1_reg) * 50'(vi1_reg);
        vi2_next = vi_sq[47:0];
        da_s     = $signed({2'b00, vm}) - $signed({vi1_reg[VI_W-1], vi1_reg});
        da_u     = da_s[24:0];
        da2_next = 50'(da_u) * 50'(da_u);
    end

    // ---------------- stage 3: sums ----------------
    logic                   v3_reg;
    logic [48:0]            two_ad3_reg;
    logic [47:0]            diff3_reg;
    logic [49:0]            p3_reg;
    logic [NUM_W-1:0]       num3_reg;
    logic [SQ_IN_W-1:0]     sqa3_reg;
    logic [SQ_IN_W-1:0]     sqb3_reg;
    logic [48:0]            twovm3_reg;
    logic [DEN_W-1:0]       dcr3_reg;
    logic                   ge3_reg;
    logic signed [VI_W-1:0] vi3_reg;
    logic [D_W-1:0]         vf3_reg;
    logic [D_W-1:0]         a3_reg;
    logic [48:0]            two_ad3_next;

    assign two_ad3_next = {ad2_reg, 1'b0};

    // ---------------- stage 4: case select ----------------
    logic               v4_reg;
    logic [SQ_IN_W-1:0] op4_reg;
    ttt_side_t          side4_reg;
    logic [SQ_IN_W-1:0] op4_next;
    ttt_side_t          side4_next;

    always_comb begin
        logic reach;
        logic cruise;
        reach  = {1'b0, diff3_reg} > two_ad3_reg;
        cruise = p3_reg > 50'(twovm3_reg);
        side4_next.vi  = vi3_reg;
        side4_next.vf  = vf3_reg;
        side4_next.num = num3_reg;
        side4_next.den = DEN_W'(a3_reg);
        if (reach) begin
            side4_next.sel = ge3_reg ? CASE_ACCEL : CASE_DECEL;
            op4_next       = ge3_reg ? sqa3_reg : sqb3_reg;
        end else if (cruise) begin
            side4_next.sel = CASE_CRUISE;
            side4_next.den = dcr3_reg;
            op4_next       = '0;
        end else begin
            side4_next.sel = CASE_TRI;
            op4_next       = SQ_IN_W'({p3_reg, 1'b0});
        end
    end

    // ---------------- square root ----------------
    logic            sq_valid;
    logic [SQ_W-1:0] sq_root;
    ttt_side_t       sq_side;

    ttt_isqrt_pipe u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (v4_reg),
        .in_op    (op4_reg),
        .in_side  (side4_reg),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // ---------------- stage 5: dividend, saturation check ----------------
    logic     v5_reg;
    ttt_div_t div5_reg;
    ttt_div_t div5_next;

    always_comb begin
        logic signed [27:0] root_s;
        logic signed [27:0] vi_s;
        logic signed [27:0] vf_s;
        logic signed [27:0] nsig;
        logic [NUM_W-1:0]   n;
        logic [NSH_W-1:0]   nsh;
        logic [NSH_W-1:0]   hi;
        root_s = $signed({2'b00, sq_root});
        vi_s   = {{3{sq_side.vi[VI_W-1]}}, sq_side.vi};
        vf_s   = $signed({4'b0000, sq_side.vf});
        case (sq_side.sel)
            CASE_ACCEL: nsig = root_s - vi_s;
            CASE_DECEL: nsig = vi_s - root_s;
            CASE_TRI:   nsig = root_s - vi_s - vf_s;
            default:    nsig = '0;
        endcase
        if (sq_side.sel == CASE_CRUISE) begin
            n = sq_side.num;
        end else if (nsig[27]) begin
            n = '0;
        end else begin
            n = NUM_W'(nsig[26:0]);
        end
        case (sq_side.sel)
            CASE_TRI:    div5_next.prof = PROF_TRI;
            CASE_CRUISE: div5_next.prof = PROF_CRUISE;
            default:     div5_next.prof = PROF_REACH;
        endcase
        // quotient of n * 2^F fits T_W bits only if (n * 2^F) >> T_W < den
        nsh            = {n, {FRAC_BITS{1'b0}}};
        hi             = nsh >> T_W;
        div5_next.den  = sq_side.den;
        div5_next.sat  = (sq_side.den == '0) || (hi >= NSH_W'(sq_side.den));
        div5_next.rem  = div5_next.sat ? '0 : hi[DEN_W-1:0];
        div5_next.bits = nsh[T_W-1:0];
    end

    // ---------------- divider ----------------
    logic     dv_valid;
    ttt_div_t dv_out;

    ttt_div_pipe u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (v5_reg),
        .in_div   (div5_reg),
        .out_valid(dv_valid),
        .out_div  (dv_out)
    );

    // ---------------- output register ----------------
    logic [T_W-1:0]    m_travel_time_reg;
    logic [PROF_W-1:0] m_profile_reg;
    logic              m_saturated_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= sq_valid;
            m_valid_reg <= dv_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg  <= d1_next;
            vi1_reg <= vi1_next;
            vf1_reg <= vf1_next;

            vi2_reg  <= vi2_next;
            vf2_reg  <= 48'(vf1_reg) * 48'(vf1_reg);
            ad2_reg  <= 48'(acc) * 48'(d1_reg);
            da2_reg  <= da2_next;
            dd2_reg  <= 48'(vm - vf1_reg) * 48'(vm - vf1_reg);
            vm2_reg  <= 48'(vm) * 48'(vm);
            avm2_reg <= 48'(acc) * 48'(vm);
            vi2s_reg <= vi1_reg;
            vf2s_reg <= vf1_reg;
            a2_reg   <= acc;

            two_ad3_reg <= two_ad3_next;
            diff3_reg   <= (vf2_reg >= vi2_reg) ? vf2_reg - vi2_reg : vi2_reg - vf2_reg;
            p3_reg      <= 50'(two_ad3_next) + 50'(vi2_reg) + 50'(vf2_reg);
            num3_reg    <= NUM_W'(da2_reg) + NUM_W'(dd2_reg) + NUM_W'(two_ad3_next);
            sqa3_reg    <= SQ_IN_W'(vi2_reg) + SQ_IN_W'(two_ad3_next);
            sqb3_reg    <= SQ_IN_W'(vi2_reg) - SQ_IN_W'(two_ad3_next);
            twovm3_reg  <= {vm2_reg, 1'b0};
            dcr3_reg    <= {avm2_reg, 1'b0};
            ge3_reg     <= $signed({1'b0, vf2s_reg}) >= vi2s_reg;
            vi3_reg     <= vi2s_reg;
            vf3_reg     <= vf2s_reg;
            a3_reg      <= a2_reg;

            op4_reg   <= op4_next;
            side4_reg <= side4_next;

            div5_reg <= div5_next;

            m_travel_time_reg <= dv_out.sat ? '1 : dv_out.bits;
            m_profile_reg     <= dv_out.prof;
            m_saturated_reg   <= dv_out.sat;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_travel_time = m_travel_time_reg;
    assign m_profile     = m_profile_reg;
    assign m_saturated   = m_saturated_reg;

`ifndef SYNTHESIS
    // a saturated result always reads as the largest time
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_saturated_reg |-> m_travel_time_reg == '1)
        else $error("saturated result without full-scale time");

    // cruise with zero speed limit divides by zero and must saturate
    a_zero_vm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_profile_reg == PROF_CRUISE && speed_limit_reg == '0
        |-> m_saturated_reg)
        else $error("cruise with zero speed limit not saturated");

    // no result leaves right after reset
    a_rst_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid_reg)
        else $error("result valid after reset");

    // a held result is not overwritten by the pipeline
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_travel_time_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for trapezoid_travel_time_unit.
// Depends on rtl/ttt_pkg.sv and the unit's RTL; predicts every result in place.
`timescale 1ns / 1ps

module tb
    import ttt_pkg::*;
();

    // one input item: distance, start and end velocity
    typedef struct {
        logic signed [D_W-1:0] travel;
        logic signed [D_W-1:0] v_start;
        logic signed [D_W-1:0] v_end;
    } leg_t;

    // one predicted result
    typedef struct {
        logic [T_W-1:0] t_sec;
        ttt_prof_t      prof;
        logic           sat;
    } travel_res_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [0:0]            cfg_addr = CFG_SPEED_LIMIT;
    logic [D_W-1:0]        cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [D_W-1:0] s_travel_distance = '0;
    logic signed [D_W-1:0] s_start_velocity = '0;
    logic signed [D_W-1:0] s_end_velocity = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [T_W-1:0]        m_travel_time;
    logic [PROF_W-1:0]     m_profile;
    logic                  m_saturated;

    trapezoid_travel_time_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_travel_distance (s_travel_distance),
        .s_start_velocity  (s_start_velocity),
        .s_end_velocity    (s_end_velocity),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_travel_time     (m_travel_time),
        .m_profile         (m_profile),
        .m_saturated       (m_saturated)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // limit copies, updated only while nothing is in flight
    logic [D_W-1:0] spd_lim = 24'd196608;
    logic [D_W-1:0] acc_lim = 24'd196608;

    leg_t        legs_pending[$];
    travel_res_t due_results[$];

    int  err_cnt = 0;
    int  results_seen = 0;
    int  prof_cnt[3] = '{0, 0, 0};
    int  sat_cnt = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  long_hold = 0;
    bit  long_hold_done = 1'b0;
    bit  quiet = 1'b0;

    // floored integer square root, one result bit per pass
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // {sat, floor(num * 2^16 / den)} saturated to 32 bits; zero den saturates
    function automatic logic [T_W:0] scaled_quot(longint unsigned num, longint unsigned den);
        logic [127:0] q;
        if (den == 0) return {1'b1, {T_W{1'b1}}};
        q = ({64'd0, num} << 16) / {64'd0, den};
        if (q > 128'hFFFF_FFFF) return {1'b1, {T_W{1'b1}}};
        return {1'b0, q[T_W-1:0]};
    endfunction

    function automatic travel_res_t predict_travel(logic signed [D_W-1:0] dist_in,
                                                   logic signed [D_W-1:0] vs_in,
                                                   logic signed [D_W-1:0] ve_in);
        longint d, vi, vf, vm, a, two_ad, vi2, vf2, gap, p, n, da, dd;
        longint unsigned den;
        logic [T_W:0] q;
        travel_res_t r;
        d  = dist_in;
        vi = vs_in;
        vf = ve_in;
        vm = spd_lim;
        a  = (acc_lim == 0) ? 1 : acc_lim;
        if (d < 0) d = 0;
        if (vi > vm) vi = vm;
        if (vf < 0) vf = 0;
        if (vf > vm) vf = vm;
        two_ad = 2 * a * d;
        vi2    = vi * vi;
        vf2    = vf * vf;
        gap    = (vf2 > vi2) ? vf2 - vi2 : vi2 - vf2;
        if (gap > two_ad) begin
            // end velocity not reachable: accelerate or brake throughout
            r.prof = PROF_REACH;
            if (vf >= vi) n = longint'(root_floor(vi2 + two_ad)) - vi;
            else          n = vi - longint'(root_floor(vi2 - two_ad));
            if (n < 0) n = 0;
            den = a;
        end else begin
            p = two_ad + vi2 + vf2;
            if (p > 2 * vm * vm) begin
                r.prof = PROF_CRUISE;
                da  = vm - vi;
                dd  = vm - vf;
                n   = da * da + dd * dd + two_ad;
                den = 2 * a * vm;
            end else begin
                r.prof = PROF_TRI;
                n = longint'(root_floor(2 * p)) - vi - vf;
                if (n < 0) n = 0;
                den = a;
            end
        end
        q       = scaled_quot(n, den);
        r.sat   = q[T_W];
        r.t_sec = q[T_W-1:0];
        return r;
    endfunction

    // random velocity within about +-1.25x of the current speed limit
    function automatic logic signed [D_W-1:0] near_speed(longint vsc);
        longint v;
        v = longint'($urandom_range(0, 32'(vsc * 5 / 2))) - vsc * 5 / 4;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return D_W'(v);
    endfunction

    function automatic leg_t make_leg();
        leg_t   lg;
        longint vsc, reach, a;
        int     mode;
        vsc  = (spd_lim == 0) ? 4096 : spd_lim;
        a    = (acc_lim == 0) ? 1 : acc_lim;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            // raw noise over the whole field range
            lg.travel  = D_W'($urandom);
            lg.v_start = D_W'($urandom);
            lg.v_end   = D_W'($urandom);
        end else begin
            // distance around what it takes to reach the speed limit
            reach = vsc * vsc / a;
            if (reach > 8388607 || reach < 0) reach = 8388607;
            lg.travel  = D_W'($urandom_range(0, 32'(reach)));
            lg.v_start = near_speed(vsc);
            lg.v_end   = near_speed(vsc);
            if (mode == 2) lg.travel = -D_W'($urandom_range(0, 8388608));
            if (mode == 3) lg.v_start = '0;
            if (mode == 4 && $urandom_range(0, 1)) lg.v_end = lg.v_start;
        end
        return lg;
    endfunction

    task automatic add_leg(int travel, int vs, int ve);
        leg_t lg;
        lg.travel  = D_W'(travel);
        lg.v_start = D_W'(vs);
        lg.v_end   = D_W'(ve);
        legs_pending.push_back(lg);
    endtask

    task automatic note_mismatch(string what, longint exp_v, longint got_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    endtask

    // blocks until the unit holds no item and nothing is queued
    task automatic wait_drained();
        do @(posedge aclk);
        while (legs_pending.size() != 0 || s_valid || due_results.size() != 0);
        repeat (70) @(posedge aclk);
    endtask

    task automatic write_limit(ttt_cfg_t idx, logic [D_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SPEED_LIMIT) spd_lim = val;
        else                        acc_lim = val;
    endtask

    // Driver: offers the queued items, holds valid until each is taken,
    // and inserts random idle bursts unless the quiet tail has begun.
    always @(posedge aclk) begin
        leg_t lg;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                due_results.push_back(predict_travel(s_travel_distance,
                                                     s_start_velocity,
                                                     s_end_velocity));
            if (s_valid && !s_ready) begin
                // hold the offered item unchanged
            end else if (send_gap > 0 && !quiet) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (legs_pending.size() != 0) begin
                lg = legs_pending.pop_front();
                s_valid           <= 1'b1;
                s_travel_distance <= lg.travel;
                s_start_velocity  <= lg.v_start;
                s_end_velocity    <= lg.v_end;
                if ($urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 18);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken result against the oldest prediction.
    // After 300 results it stalls once, holding m_ready low, so the pipeline fills
    // and the input side backs up.
    always @(posedge aclk) begin
        travel_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    note_mismatch("result with nothing expected", 0, m_travel_time);
                end else begin
                    want = due_results.pop_front();
                    if (m_travel_time !== want.t_sec)
                        note_mismatch("travel_time", want.t_sec, m_travel_time);
                    if (m_profile !== want.prof)
                        note_mismatch("profile", want.prof, m_profile);
                    if (m_saturated !== want.sat)
                        note_mismatch("saturated", want.sat, m_saturated);
                    if (want.prof <= PROF_CRUISE) prof_cnt[want.prof]++;
                    if (want.sat) sat_cnt++;
                end
            end
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                long_hold      = 400;
            end
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                long_hold--;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 18);
            end
        end
    end

    // Stimulus: reset limits first with directed corners, then phases at
    // other limit settings, each started only once the unit has drained.
    initial begin
        logic [D_W-1:0] spd_set[8];
        logic [D_W-1:0] acc_set[8];
        spd_set = '{24'd196608, 24'd0, 24'hFFFFFF, 24'd65536, 24'd1,
                    24'd0, 24'd0, 24'd0};
        acc_set = '{24'd196608, 24'd1, 24'hFFFFFF, 24'd1, 24'd0,
                    24'd0, 24'd0, 24'd0};
        for (int i = 5; i < 8; i++) begin
            spd_set[i] = D_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20));
            acc_set[i] = D_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20));
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners at the reset limits (3.0 units, 3.0 units/s^2)
        add_leg(0, 0, 0);
        add_leg(8388607, 8388607, 8388607);
        add_leg(-8388608, -8388608, -8388608);
        add_leg(-100, 65536, 0);             // negative distance, brake to stop
        add_leg(8388607, 0, 0);              // long run: cruise at the limit
        add_leg(65536, 0, 0);                // short run: triangle
        add_leg(1000, 0, 196608);            // end speed out of reach, speeding up
        add_leg(1000, 196608, 0);            // end speed out of reach, slowing down
        add_leg(65536, -196608, 0);          // starting away from the target
        add_leg(65536, 400000, -5);          // start above limit, end below zero
        add_leg(65536, 0, 8388607);          // end speed above limit
        add_leg(1, 1, 1);
        add_leg(-1, -1, -1);
        add_leg(8388607, -8388608, 0);
        for (int k = 0; k < 136; k++) legs_pending.push_back(make_leg());
        wait_drained();

        for (int ph = 1; ph < 8; ph++) begin
            write_limit(CFG_SPEED_LIMIT, spd_set[ph]);
            write_limit(CFG_ACCEL_LIMIT, acc_set[ph]);
            if (ph == 7) quiet = 1'b1;
            for (int k = 0; k < 150; k++) legs_pending.push_back(make_leg());
            wait_drained();
        end

        $display("Covered %0d items over 8 limit settings incl. zero speed and accel.",
                 results_seen);
        $display("Profiles reach/tri/cruise: %0d/%0d/%0d, saturated: %0d",
                 prof_cnt[0], prof_cnt[1], prof_cnt[2], sat_cnt);
        if (err_cnt == 0 && due_results.size() == 0)
            $display("trapezoid_travel_time_unit: match");
        else
            $display("trapezoid_travel_time_unit: mismatch");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("trapezoid_travel_time_unit: mismatch");
        $finish;
    end

endmodule
